// File: src/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg: shared types and helpers for the form URL percent decoder
// Character codes, escape state encoding, per-field state and result types.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int OUT_COUNT_BITS = 16;

  localparam logic [COUNT_BITS-1:0]     COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = {OUT_COUNT_BITS{1'b1}};

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DEL     = 8'h7F;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HIGH = 2'd2
  } esc_phase_t;

  typedef struct packed {
    esc_phase_t            phase;
    logic [3:0]            nibble;
    logic [COUNT_BITS-1:0] count;
    logic                  err;
  } field_state_t;

  typedef struct packed {
    logic [7:0]                out_byte;
    logic                      byte_valid;
    logic                      done_res;
    logic                      status;
    logic [OUT_COUNT_BITS-1:0] decoded_count;
  } result_t;

  localparam field_state_t FIELD_RESET = '{
    phase:  ESC_IDLE,
    nibble: 4'h0,
    count:  '0,
    err:    1'b0
  };

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic forbidden(input logic [7:0] b);
    logic f;
    f = (b == CHAR_DEL) ||
        (b < CHAR_SPACE && b != CHAR_TAB && b != CHAR_LF && b != CHAR_CR);
    return f;
  endfunction

  function automatic logic [OUT_COUNT_BITS-1:0] show_count(
      input logic [COUNT_BITS-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    return (w > 33'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : w[OUT_COUNT_BITS-1:0];
  endfunction

endpackage

// File: src/fud_if.sv
// ----------------------------------------------------------------------------
// fud_if: request channels of the form URL percent decoder
// Valid/ready channels for source characters and decoded results.
// ----------------------------------------------------------------------------
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface fud_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        done_res;
  logic        status;
  logic [15:0] decoded_count;

  modport source (output valid, output out_byte, output byte_valid,
                  output done_res, output status, output decoded_count,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input done_res, input status, input decoded_count,
                  output ready);
endinterface

// File: src/fud_step.sv
// ----------------------------------------------------------------------------
// fud_step: per-character decode step
// Given the field state and one character, forms the next state and the
// result (if any) for that character.
// ----------------------------------------------------------------------------
module fud_step
  import fud_pkg::*;
(
  input  field_state_t st,
  input  logic [7:0]   char_in,
  input  logic         is_last,
  output field_state_t st_nxt,
  output logic         res_valid,
  output result_t      res
);

  always_comb begin
    logic [4:0] hex;
    logic       have_val;
    logic       fail;
    logic [7:0] value;

    hex      = hex_value(char_in);
    have_val = 1'b0;
    fail     = 1'b0;
    value    = 8'h00;
    st_nxt   = st;
    res_valid = 1'b0;
    res      = '0;

    if (st.err) begin
      // drop until the end of the field
      if (is_last) begin
        st_nxt = FIELD_RESET;
      end
    end else begin
      unique case (st.phase)
        ESC_IDLE: begin
          if (char_in == CHAR_PERCENT) begin
            if (is_last) begin
              fail = 1'b1;
            end else begin
              st_nxt.phase = ESC_PCT;
            end
          end else if (char_in == CHAR_PLUS) begin
            value    = CHAR_SPACE;
            have_val = 1'b1;
          end else begin
            value    = char_in;
            have_val = 1'b1;
          end
        end
        ESC_PCT: begin
          if (is_last || !hex[4]) begin
            fail = 1'b1;
          end else begin
            st_nxt.nibble = hex[3:0];
            st_nxt.phase  = ESC_HIGH;
          end
        end
        default: begin
          if (!hex[4]) begin
            fail = 1'b1;
          end else begin
            value         = {st.nibble, hex[3:0]};
            have_val      = 1'b1;
            st_nxt.phase  = ESC_IDLE;
            st_nxt.nibble = 4'h0;
          end
        end
      endcase

      if (have_val && forbidden(value)) begin
        fail = 1'b1;
      end

      if (fail) begin
        res_valid         = 1'b1;
        res.done_res      = 1'b1;
        res.status        = 1'b1;
        res.decoded_count = show_count(st.count);
        if (is_last) begin
          st_nxt = FIELD_RESET;
        end else begin
          st_nxt.err    = 1'b1;
          st_nxt.phase  = ESC_IDLE;
          st_nxt.nibble = 4'h0;
        end
      end else if (have_val) begin
        st_nxt.count = (st.count < COUNT_MAX) ? st.count + 1'b1 : st.count;
        res_valid         = 1'b1;
        res.out_byte      = value;
        res.byte_valid    = 1'b1;
        res.done_res      = is_last;
        res.decoded_count = show_count(st_nxt.count);
        if (is_last) begin
          st_nxt = FIELD_RESET;
        end
      end
    end
  end

endmodule

// File: src/form_url_percent_decoder.sv
// ----------------------------------------------------------------------------
// form_url_percent_decoder: form URL (x-www-form-urlencoded) field decoder
// Input register, combinational decode step, result register.
// ----------------------------------------------------------------------------
// One source character is taken per clock, back to back, unless the output
// stalls. A character lands in the input register, is decoded against the
// field state once the result register can take it, and its result, if
// any, goes to the output through the result register. The decode step's
// state update sets the rate of one character per cycle. '%' and the first
// hex digit give no result; the first error gives one result with status
// set and done_res set, and the rest of the field up to is_last is dropped.
module form_url_percent_decoder
  import fud_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  fud_in_if.sink           in_ch,
  fud_out_if.source        out_ch
);

  logic         in_valid_r;
  logic [7:0]   in_char_r;
  logic         in_last_r;
  field_state_t state_r;
  logic         out_valid_r;
  result_t      out_res_r;

  field_state_t state_nxt;
  logic         res_valid;
  result_t      res;
  logic         advance;

  fud_step u_step (
    .st        (state_r),
    .char_in   (in_char_r),
    .is_last   (in_last_r),
    .st_nxt    (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // decode stage moves on when the result register is free or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      state_r     <= FIELD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_in;
      in_last_r <= in_ch.is_last;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_res_r.out_byte;
  assign out_ch.byte_valid    = out_res_r.byte_valid;
  assign out_ch.done_res      = out_res_r.done_res;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.decoded_count = out_res_r.decoded_count;

  // end of field always returns the state to its reset value
  a_field_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (state_r == FIELD_RESET))
    else $error("field state not cleared after last character");

  // while dropping, no escape is pending
  a_err_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.err |-> (state_r.phase == ESC_IDLE && state_r.nibble == 4'h0))
    else $error("escape pending while dropping a failed field");

  // a dropped character never produces a result
  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r.err && out_ch.ready) |=> !out_valid_r)
    else $error("result produced while dropping a failed field");

  // an accepted request always occupies the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> in_valid_r)
    else $error("accepted request lost");

endmodule
